// ===== hw/rtl/fqcp_pkg.sv =====
`default_nettype none
package fqcp_pkg;

  localparam int TRIG_FRAC_BITS = 15;
  localparam int COORD_BITS     = 12;
  localparam int POLY_BITS      = 30;
  localparam int PHASE_BITS     = 16;
  localparam int U_W            = PHASE_BITS + 1;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 1;
  localparam int SIZE_W         = 12;
  localparam int POS_W          = 16;
  localparam int OUT_W          = 17;
  localparam int CRD_W          = SIZE_W + 4;
  localparam int GAIN_W         = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  localparam logic [U_W-1:0] PHASE_ONE  = U_W'(1) << PHASE_BITS;
  localparam logic [U_W-1:0] PHASE_HALF = U_W'(1) << (PHASE_BITS - 1);

  localparam logic [SIZE_W-1:0] SIZE_MASK = SIZE_W'((64'd1 << COORD_BITS) - 64'd1);

  localparam logic [CFG_IDX_W-1:0] REG_FLIP_EDGE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_FRONT_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_FRONT_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_BACK_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_BACK_Y  = 3'd5;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd819;

  localparam logic [1:0] EDGE_TOP    = 2'd0;
  localparam logic [1:0] EDGE_LEFT   = 2'd1;
  localparam logic [1:0] EDGE_BOTTOM = 2'd2;
  localparam logic [1:0] EDGE_RIGHT  = 2'd3;

  // Q30 odd Taylor terms of sin(pi/2*u), u^1 .. u^9, alternating signs
  localparam logic signed [31:0] SIN_COEF [5] = '{
    32'sd1686629713, 32'sd693598668, 32'sd85569306, 32'sd5026995, 32'sd172272
  };

  typedef struct packed {
    logic                    fin;
    logic                    back;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [SIZE_W-1:0]       fw;
    logic [SIZE_W-1:0]       fh;
    logic [SIZE_W-1:0]       bw;
    logic [SIZE_W-1:0]       bh;
  } side_t;

  typedef struct packed {
    logic [1:0]        flip_edge;
    logic [GAIN_W-1:0] gain;
    logic [SIZE_W-1:0] pfx;
    logic [SIZE_W-1:0] pfy;
    logic [SIZE_W-1:0] pbx;
    logic [SIZE_W-1:0] pby;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fqcp_phase.sv =====
`default_nettype none
module fqcp_phase (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [15:0]                   in_elapsed,
  input  wire logic [15:0]                   in_duration,
  input  wire fqcp_pkg::side_t               in_side,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [fqcp_pkg::U_W-1:0]           out_u,
  output logic                               out_rev,
  output fqcp_pkg::side_t                    out_side
);

  localparam int STEPS      = 2;
  localparam int DIV_STAGES = fqcp_pkg::PHASE_BITS / STEPS;
  localparam int NS         = DIV_STAGES + 2;
  localparam int QW         = fqcp_pkg::PHASE_BITS;

  logic [NS-1:0] v_r;
  logic [NS:0]   adv;

  logic [15:0]     rem_r  [DIV_STAGES+1];
  logic [QW-1:0]   q_r    [DIV_STAGES+1];
  logic [15:0]     d_r    [DIV_STAGES+1];
  logic            cap_r  [DIV_STAGES+1];
  fqcp_pkg::side_t side_r [DIV_STAGES+1];

  logic [15:0]   rem_nxt [DIV_STAGES+1];
  logic [QW-1:0] q_nxt   [DIV_STAGES+1];

  logic [fqcp_pkg::U_W-1:0] u_r, u_nxt;
  logic                     rev_r, rev_nxt;
  fqcp_pkg::side_t          sidef_r;

  always_comb begin
    adv[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  // restoring division, two quotient bits per stage
  always_comb begin
    logic [15:0]   r;
    logic [QW-1:0] q;
    logic [16:0]   t;
    rem_nxt[0] = rem_r[0];
    q_nxt[0]   = q_r[0];
    for (int k = 1; k <= DIV_STAGES; k++) begin
      r = rem_r[k-1];
      q = q_r[k-1];
      for (int j = 0; j < STEPS; j++) begin
        t = {r, 1'b0};
        if (t >= {1'b0, d_r[k-1]}) begin
          t = t - {1'b0, d_r[k-1]};
          q = {q[QW-2:0], 1'b1};
        end else begin
          q = {q[QW-2:0], 1'b0};
        end
        r = t[15:0];
      end
      rem_nxt[k] = r;
      q_nxt[k]   = q;
    end
  end

  always_comb begin
    logic [fqcp_pkg::U_W-1:0] ph;
    logic [fqcp_pkg::U_W-1:0] fold;
    ph = cap_r[DIV_STAGES] ? fqcp_pkg::PHASE_ONE
                           : {1'b0, q_r[DIV_STAGES]};
    rev_nxt = ph > fqcp_pkg::PHASE_HALF;
    fold = rev_nxt ? fqcp_pkg::PHASE_ONE - ph : ph;
    u_nxt = {fold[fqcp_pkg::U_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      rem_r[0]  <= in_elapsed;
      q_r[0]    <= '0;
      d_r[0]    <= in_duration;
      cap_r[0]  <= (in_duration == 16'd0) || (in_elapsed >= in_duration);
      side_r[0] <= in_side;
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      if (adv[k]) begin
        rem_r[k]  <= rem_nxt[k];
        q_r[k]    <= q_nxt[k];
        d_r[k]    <= d_r[k-1];
        cap_r[k]  <= cap_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
    if (adv[NS-1]) begin
      u_r     <= u_nxt;
      rev_r   <= rev_nxt;
      sidef_r <= side_r[DIV_STAGES];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NS-1];
  assign out_u     = u_r;
  assign out_rev   = rev_r;
  assign out_side  = sidef_r;

endmodule
`default_nettype wire

// ===== hw/rtl/fqcp_trig.sv =====
`default_nettype none
module fqcp_trig (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [fqcp_pkg::U_W-1:0]     in_u,
  input  wire logic                         in_rev,
  input  wire fqcp_pkg::side_t              in_side,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [fqcp_pkg::TRIG_W-1:0]       out_s,
  output logic [fqcp_pkg::TRIG_W-1:0]       out_c,
  output logic                              out_rev,
  output fqcp_pkg::side_t                   out_side
);

  // stage 0 load, 1 square, 2..5 Horner, 6 final product and clamp
  localparam int NS  = 7;
  localparam int UW  = fqcp_pkg::U_W;
  localparam int X2W = 31;
  localparam int PB  = fqcp_pkg::POLY_BITS;
  localparam int FSH = 2 * PB - fqcp_pkg::TRIG_FRAC_BITS;
  localparam logic signed [63:0] TRIG_ONE = 64'sd1 <<< fqcp_pkg::TRIG_FRAC_BITS;

  logic [NS-1:0] v_r;
  logic [NS:0]   adv;

  logic [UW-1:0]        u_r   [0:NS-2][2];
  logic [X2W-1:0]       x2_r  [1:NS-2][2];
  logic signed [31:0]   p_r   [2:NS-2][2];
  logic [fqcp_pkg::TRIG_W-1:0] sc_r [2];
  logic                 rev_r  [NS];
  fqcp_pkg::side_t      side_r [NS];

  logic [X2W-1:0]                x2_nxt [2];
  logic signed [31:0]            p_nxt  [2:NS-2][2];
  logic [fqcp_pkg::TRIG_W-1:0]   sc_nxt [2];

  always_comb begin
    adv[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  always_comb begin
    logic [2*UW-1:0]      sq;
    logic signed [31:0]   xs;
    logic signed [63:0]   prod;
    logic signed [63:0]   r;
    for (int l = 0; l < 2; l++) begin
      sq = {{UW{1'b0}}, u_r[0][l]} * {{UW{1'b0}}, u_r[0][l]};
      x2_nxt[l] = sq[X2W+1:2];

      xs   = signed'({1'b0, x2_r[1][l]});
      prod = xs * fqcp_pkg::SIN_COEF[4];
      p_nxt[2][l] = fqcp_pkg::SIN_COEF[3] - 32'(prod >>> PB);

      for (int k = 3; k <= NS - 2; k++) begin
        xs   = signed'({1'b0, x2_r[k-1][l]});
        prod = xs * p_r[k-1][l];
        p_nxt[k][l] = fqcp_pkg::SIN_COEF[5-k] - 32'(prod >>> PB);
      end

      xs   = signed'({1'b0, u_r[NS-2][l], 14'd0});
      prod = xs * p_r[NS-2][l];
      r    = prod >>> FSH;
      if (r > TRIG_ONE) begin
        r = TRIG_ONE;
      end
      if (r < 64'sd0) begin
        r = 64'sd0;
      end
      sc_nxt[l] = fqcp_pkg::TRIG_W'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      u_r[0][0] <= in_u;
      u_r[0][1] <= fqcp_pkg::PHASE_ONE - in_u;
      rev_r[0]  <= in_rev;
      side_r[0] <= in_side;
    end
    for (int k = 1; k < NS; k++) begin
      if (adv[k]) begin
        rev_r[k]  <= rev_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
    for (int k = 1; k <= NS - 2; k++) begin
      if (adv[k]) begin
        u_r[k] <= u_r[k-1];
      end
    end
    if (adv[1]) begin
      x2_r[1] <= x2_nxt;
    end
    for (int k = 2; k <= NS - 2; k++) begin
      if (adv[k]) begin
        x2_r[k] <= x2_r[k-1];
        p_r[k]  <= p_nxt[k];
      end
    end
    if (adv[NS-1]) begin
      sc_r <= sc_nxt;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NS-1];
  assign out_s     = sc_r[0];
  assign out_c     = sc_r[1];
  assign out_rev   = rev_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule
`default_nettype wire

// ===== hw/rtl/fqcp_geom.sv =====
`default_nettype none
module fqcp_geom (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fqcp_pkg::cfg_t                cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [fqcp_pkg::TRIG_W-1:0]   in_s,
  input  wire logic [fqcp_pkg::TRIG_W-1:0]   in_c,
  input  wire logic                          in_rev,
  input  wire fqcp_pkg::side_t               in_side,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_face,
  output logic [fqcp_pkg::OUT_W-1:0]         out_x [4],
  output logic [fqcp_pkg::OUT_W-1:0]         out_y [4]
);

  localparam int NS   = 6;
  localparam int SW   = fqcp_pkg::SIZE_W;
  localparam int TW   = fqcp_pkg::TRIG_W;
  localparam int CW   = fqcp_pkg::CRD_W;
  localparam int OW   = fqcp_pkg::OUT_W;
  localparam int PW   = fqcp_pkg::POS_W;
  localparam int T    = fqcp_pkg::TRIG_FRAC_BITS;
  localparam int D_W  = SW + 1;
  localparam int C_W  = TW + 1;
  localparam int M_W  = D_W + C_W;
  localparam int SK_W = TW + SW;
  localparam int K_W  = SK_W + fqcp_pkg::GAIN_W;
  localparam int FB   = T + 16;

  function automatic logic signed [M_W-1:0] shr_zero(input logic signed [M_W-1:0] v);
    logic [M_W-1:0] a;
    a = v[M_W-1] ? M_W'(-v) : M_W'(v);
    a = a >> T;
    return v[M_W-1] ? -signed'(a) : signed'(a);
  endfunction

  logic [NS-1:0] v_r;
  logic [NS:0]   adv;

  // stage 0
  fqcp_pkg::side_t side0_r;
  logic            rev0_r;
  logic [TW-1:0]   s0_r, c0_r;

  // stage 1
  logic                 fin1_r, face1_r, face1_nxt;
  logic [1:0]           edge1_r, edge1_nxt;
  logic [SW-1:0]        cx1_r, cy1_r, cx1_nxt, cy1_nxt;
  logic [SW-1:0]        span1_r, piv1_r, ks1_r;
  logic [TW-1:0]        s1_r, c1_r;
  logic signed [PW-1:0] px1_r, py1_r;

  // stage 2
  logic signed [M_W-1:0] mlo2_r, mhi2_r, mlo2_nxt, mhi2_nxt;
  logic [SK_W-1:0]       sk2_r;
  logic [SW-1:0]         piv2_r, cx2_r, cy2_r;
  logic                  fin2_r, face2_r;
  logic [1:0]            edge2_r;
  logic signed [PW-1:0]  px2_r, py2_r;

  // stage 3
  logic signed [CW-1:0]  lo3_r, hi3_r, lo3_nxt, hi3_nxt;
  logic [K_W-1:0]        k3_r;
  logic [SW-1:0]         cx3_r, cy3_r;
  logic                  fin3_r, face3_r;
  logic [1:0]            edge3_r;
  logic signed [PW-1:0]  px3_r, py3_r;

  // stage 4
  logic signed [CW-1:0]  x4_r [4], y4_r [4], x4_nxt [4], y4_nxt [4];
  logic                  face4_r;
  logic signed [PW-1:0]  px4_r, py4_r;

  // stage 5
  logic [OW-1:0] x5_r [4], y5_r [4];
  logic          face5_r;

  always_comb begin
    adv[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  // face, size and hinge selection
  always_comb begin
    face1_nxt = side0_r.fin ? side0_r.back : (side0_r.back ^ rev0_r);
    cx1_nxt   = face1_nxt ? side0_r.bw : side0_r.fw;
    cy1_nxt   = face1_nxt ? side0_r.bh : side0_r.fh;
    edge1_nxt = face1_nxt ? (cfg.flip_edge ^ fqcp_pkg::EDGE_BOTTOM) : cfg.flip_edge;
  end

  always_comb begin
    logic signed [D_W-1:0] dlo, dhi;
    logic signed [C_W-1:0] cs;
    dlo = signed'(D_W'(0)) - signed'(D_W'(piv1_r));
    dhi = signed'(D_W'(span1_r)) - signed'(D_W'(piv1_r));
    cs  = signed'(C_W'(c1_r));
    mlo2_nxt = dlo * cs;
    mhi2_nxt = dhi * cs;
  end

  always_comb begin
    lo3_nxt = CW'(shr_zero(mlo2_r)) + signed'(CW'(piv2_r));
    hi3_nxt = CW'(shr_zero(mhi2_r)) + signed'(CW'(piv2_r));
  end

  always_comb begin
    logic signed [CW-1:0] kq, cx, cy;
    kq = signed'(CW'(k3_r >> FB));
    cx = signed'(CW'(cx3_r));
    cy = signed'(CW'(cy3_r));
    x4_nxt = '{'0, cx, cx, '0};
    y4_nxt = '{'0, '0, cy, cy};
    if (!fin3_r) begin
      case (edge3_r)
        fqcp_pkg::EDGE_TOP: begin
          y4_nxt = '{lo3_r, lo3_r, hi3_r, hi3_r};
          x4_nxt[2] = cx + kq;
          x4_nxt[3] = -kq;
        end
        fqcp_pkg::EDGE_BOTTOM: begin
          y4_nxt = '{lo3_r, lo3_r, hi3_r, hi3_r};
          x4_nxt[0] = -kq;
          x4_nxt[1] = cx + kq;
        end
        fqcp_pkg::EDGE_LEFT: begin
          x4_nxt = '{lo3_r, hi3_r, hi3_r, lo3_r};
          y4_nxt[1] = -kq;
          y4_nxt[2] = cy + kq;
        end
        default: begin
          x4_nxt = '{lo3_r, hi3_r, hi3_r, lo3_r};
          y4_nxt[0] = -kq;
          y4_nxt[3] = cy + kq;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      side0_r <= in_side;
      rev0_r  <= in_rev;
      s0_r    <= in_s;
      c0_r    <= in_c;
    end
    if (adv[1]) begin
      fin1_r  <= side0_r.fin;
      face1_r <= face1_nxt;
      edge1_r <= edge1_nxt;
      cx1_r   <= cx1_nxt;
      cy1_r   <= cy1_nxt;
      if (!edge1_nxt[0]) begin
        span1_r <= cy1_nxt;
        ks1_r   <= cx1_nxt;
        piv1_r  <= side0_r.back ? cfg.pby : cfg.pfy;
      end else begin
        span1_r <= cx1_nxt;
        ks1_r   <= cy1_nxt;
        piv1_r  <= side0_r.back ? cfg.pbx : cfg.pfx;
      end
      s1_r  <= s0_r;
      c1_r  <= c0_r;
      px1_r <= side0_r.pos_x;
      py1_r <= side0_r.pos_y;
    end
    if (adv[2]) begin
      mlo2_r  <= mlo2_nxt;
      mhi2_r  <= mhi2_nxt;
      sk2_r   <= SK_W'(s1_r) * SK_W'(ks1_r);
      piv2_r  <= piv1_r;
      cx2_r   <= cx1_r;
      cy2_r   <= cy1_r;
      fin2_r  <= fin1_r;
      face2_r <= face1_r;
      edge2_r <= edge1_r;
      px2_r   <= px1_r;
      py2_r   <= py1_r;
    end
    if (adv[3]) begin
      lo3_r   <= lo3_nxt;
      hi3_r   <= hi3_nxt;
      k3_r    <= K_W'(sk2_r) * K_W'(cfg.gain);
      cx3_r   <= cx2_r;
      cy3_r   <= cy2_r;
      fin3_r  <= fin2_r;
      face3_r <= face2_r;
      edge3_r <= edge2_r;
      px3_r   <= px2_r;
      py3_r   <= py2_r;
    end
    if (adv[4]) begin
      x4_r    <= x4_nxt;
      y4_r    <= y4_nxt;
      face4_r <= face3_r;
      px4_r   <= px3_r;
      py4_r   <= py3_r;
    end
    if (adv[5]) begin
      for (int i = 0; i < 4; i++) begin
        x5_r[i] <= OW'(x4_r[i]) + OW'(px4_r);
        y5_r[i] <= OW'(y4_r[i]) + OW'(py4_r);
      end
      face5_r <= face4_r;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NS-1];
  assign out_face  = face5_r;
  assign out_x     = x5_r;
  assign out_y     = y5_r;

endmodule
`default_nettype wire

// ===== hw/rtl/flip_quad_corner_projection_core.sv =====
// Channel  Side    Handshake             Payload
// in       slave   in_tvalid/in_tready   tdata 112 b, tuser 2 b
// out      master  out_tvalid/out_tready tdata 136 b, tuser 1 b
// cfg      slave   cfg_valid/cfg_ready   index 3 b, data 16 b
// One item per cycle unless the output stalls; items pass the phase divider and fold,
// the two sine polynomials (a multiply per stage past the load), then the corner math.
// Reset clears all valid bits and loads the register defaults.
// Each stage moves when it is empty or the next one moves, so a stalled output
// holds its transfer while bubbles upstream still fill.
`default_nettype none
module flip_quad_corner_projection_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // elapsed, duration, pos_x, pos_y, front_width, front_height, back_width, back_height
  input  wire logic [111:0] in_tdata,
  // finished, back_showing
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // corner1_x, corner1_y, corner2_x, corner2_y, corner3_x, corner3_y, corner4_x, corner4_y
  output logic [135:0]      out_tdata,
  // face_drawn
  output logic [0:0]        out_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [fqcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fqcp_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int OW = fqcp_pkg::OUT_W;

  fqcp_pkg::cfg_t  cfg_r;
  fqcp_pkg::side_t in_side;

  logic                         ph_valid, ph_ready, ph_rev;
  logic [fqcp_pkg::U_W-1:0]     ph_u;
  fqcp_pkg::side_t              ph_side;
  logic                         tr_valid, tr_ready, tr_rev;
  logic [fqcp_pkg::TRIG_W-1:0]  tr_s, tr_c;
  fqcp_pkg::side_t              tr_side;
  logic [OW-1:0]                gx [4];
  logic [OW-1:0]                gy [4];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flip_edge <= fqcp_pkg::EDGE_TOP;
      cfg_r.gain      <= fqcp_pkg::GAIN_RESET;
      cfg_r.pfx       <= '0;
      cfg_r.pfy       <= '0;
      cfg_r.pbx       <= '0;
      cfg_r.pby       <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fqcp_pkg::REG_FLIP_EDGE:     cfg_r.flip_edge <= cfg_data[1:0];
        fqcp_pkg::REG_GAIN:          cfg_r.gain      <= cfg_data;
        fqcp_pkg::REG_PIVOT_FRONT_X: cfg_r.pfx <= cfg_data[11:0] & fqcp_pkg::SIZE_MASK;
        fqcp_pkg::REG_PIVOT_FRONT_Y: cfg_r.pfy <= cfg_data[11:0] & fqcp_pkg::SIZE_MASK;
        fqcp_pkg::REG_PIVOT_BACK_X:  cfg_r.pbx <= cfg_data[11:0] & fqcp_pkg::SIZE_MASK;
        fqcp_pkg::REG_PIVOT_BACK_Y:  cfg_r.pby <= cfg_data[11:0] & fqcp_pkg::SIZE_MASK;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_side.fin   = in_tuser[0];
    in_side.back  = in_tuser[1];
    in_side.pos_x = signed'(in_tdata[47:32]);
    in_side.pos_y = signed'(in_tdata[63:48]);
    in_side.fw    = in_tdata[75:64]   & fqcp_pkg::SIZE_MASK;
    in_side.fh    = in_tdata[87:76]   & fqcp_pkg::SIZE_MASK;
    in_side.bw    = in_tdata[99:88]   & fqcp_pkg::SIZE_MASK;
    in_side.bh    = in_tdata[111:100] & fqcp_pkg::SIZE_MASK;
  end

  fqcp_phase u_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_elapsed  (in_tdata[15:0]),
    .in_duration (in_tdata[31:16]),
    .in_side     (in_side),
    .out_valid   (ph_valid),
    .out_ready   (ph_ready),
    .out_u       (ph_u),
    .out_rev     (ph_rev),
    .out_side    (ph_side)
  );

  fqcp_trig u_trig (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ph_valid),
    .in_ready  (ph_ready),
    .in_u      (ph_u),
    .in_rev    (ph_rev),
    .in_side   (ph_side),
    .out_valid (tr_valid),
    .out_ready (tr_ready),
    .out_s     (tr_s),
    .out_c     (tr_c),
    .out_rev   (tr_rev),
    .out_side  (tr_side)
  );

  fqcp_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (tr_valid),
    .in_ready  (tr_ready),
    .in_s      (tr_s),
    .in_c      (tr_c),
    .in_rev    (tr_rev),
    .in_side   (tr_side),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_face  (out_tuser[0]),
    .out_x     (gx),
    .out_y     (gy)
  );

  assign out_tdata = {gy[3], gx[3], gy[2], gx[2], gy[1], gx[1], gy[0], gx[0]};

endmodule
`default_nettype wire

// ===== verif/flip_quad_corner_projection_core_tb.sv =====
`timescale 1ns / 1ps
module flip_quad_corner_projection_core_tb;

  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int CALM_ITEMS = 200;

  typedef struct {
    logic [15:0] elapsed;
    logic [15:0] duration;
    logic        fin;
    logic        back;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [11:0] fw;
    logic [11:0] fh;
    logic [11:0] bw;
    logic [11:0] bh;
  } card_req_t;

  typedef struct {
    logic         face;
    logic [135:0] corners;
  } quad_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [111:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [135:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [fqcp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fqcp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  flip_quad_corner_projection_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // shadow registers
  logic [1:0]  sh_edge = fqcp_pkg::EDGE_TOP;
  logic [15:0] sh_gain = fqcp_pkg::GAIN_RESET;
  logic [11:0] sh_pfx = '0, sh_pfy = '0, sh_pbx = '0, sh_pby = '0;

  card_req_t pending_reqs[$];
  quad_t expected_quads[$];
  int errors = 0;
  int sent_count = 0;
  int total_items = 0;
  int idle_cycles = 0;
  bit calm = 0;
  bit in_fire = 1'b0;

  function automatic longint sine_q15(longint u);
    longint x, x2, p, r;
    longint coef[5];
    coef = '{1686629713, 693598668, 85569306, 5026995, 172272};
    x = u <<< 14;
    x2 = (x * x) >>> 30;
    p = coef[4];
    for (int i = 3; i >= 0; i--) p = coef[i] - ((x2 * p) >>> 30);
    r = ((x * p) >>> 30) >>> 15;
    if (r > 32768) r = 32768;
    if (r < 0) r = 0;
    return r;
  endfunction

  function automatic longint trunc_shr(longint v, int sh);
    if (v < 0) return -((-v) >>> sh);
    return v >>> sh;
  endfunction

  function automatic longint scale_pivot(longint v, longint piv, longint c);
    return trunc_shr((v - piv) * c, 15) + piv;
  endfunction

  function automatic quad_t project_card(card_req_t r);
    quad_t q;
    longint x[4], y[4];
    longint cx, cy, s, c, pvx, pvy, skew, px, py, phase, lo, hi;
    logic face, rev;
    logic [1:0] e;
    px = longint'($signed(r.pos_x));
    py = longint'($signed(r.pos_y));
    if (r.fin) begin
      face = r.back;
      cx = r.back ? r.bw : r.fw;
      cy = r.back ? r.bh : r.fh;
      x = '{0, cx, cx, 0};
      y = '{0, 0, cy, cy};
    end else begin
      if (r.duration == 0) phase = 65536;
      else begin
        phase = (longint'(r.elapsed) << 16) / longint'(r.duration);
        if (phase > 65536) phase = 65536;
      end
      rev = phase > 32768;
      if (rev) phase = 65536 - phase;
      s = sine_q15(phase * 2);
      c = sine_q15(65536 - phase * 2);
      face = r.back ^ rev;
      cx = face ? r.bw : r.fw;
      cy = face ? r.bh : r.fh;
      e = face ? (sh_edge ^ fqcp_pkg::EDGE_BOTTOM) : sh_edge;
      pvx = r.back ? sh_pbx : sh_pfx;
      pvy = r.back ? sh_pby : sh_pfy;
      x = '{0, cx, cx, 0};
      y = '{0, 0, cy, cy};
      if (e == fqcp_pkg::EDGE_TOP || e == fqcp_pkg::EDGE_BOTTOM) begin
        lo = scale_pivot(0, pvy, c);
        hi = scale_pivot(cy, pvy, c);
        skew = s * cx * longint'(sh_gain);
        y = '{lo, lo, hi, hi};
        if (e == fqcp_pkg::EDGE_TOP) begin
          x[2] = trunc_shr((cx <<< 31) + skew, 31);
          x[3] = trunc_shr(-skew, 31);
        end else begin
          x[0] = trunc_shr(-skew, 31);
          x[1] = trunc_shr((cx <<< 31) + skew, 31);
        end
      end else begin
        lo = scale_pivot(0, pvx, c);
        hi = scale_pivot(cx, pvx, c);
        skew = s * cy * longint'(sh_gain);
        x = '{lo, hi, hi, lo};
        if (e == fqcp_pkg::EDGE_LEFT) begin
          y[1] = trunc_shr(-skew, 31);
          y[2] = trunc_shr((cy <<< 31) + skew, 31);
        end else begin
          y[0] = trunc_shr(-skew, 31);
          y[3] = trunc_shr((cy <<< 31) + skew, 31);
        end
      end
    end
    q.face = face;
    for (int k = 0; k < 4; k++) begin
      q.corners[34*k +: 17] = 17'(x[k] + px);
      q.corners[34*k + 17 +: 17] = 17'(y[k] + py);
    end
    return q;
  endfunction

  // driver
  int in_gap = 0;
  card_req_t cur;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_fire) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur = pending_reqs.pop_front();
          in_tdata <= {cur.bh, cur.bw, cur.fh, cur.fw, cur.pos_y, cur.pos_x,
                       cur.duration, cur.elapsed};
          in_tuser <= {cur.back, cur.fin};
          in_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 14);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure
  int out_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 14);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    quad_t exp_q;
    if (rst_n) begin
      in_fire = in_tvalid && in_tready;
      if (in_fire) begin
        expected_quads.push_back(project_card(cur));
        sent_count <= sent_count + 1;
      end
      if (in_fire || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_tvalid && out_tready) begin
        if (expected_quads.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transfer: face=%0d corners=%h",
                                     out_tuser, out_tdata);
        end else begin
          exp_q = expected_quads.pop_front();
          if (exp_q.face !== out_tuser[0] || exp_q.corners !== out_tdata) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: face exp %0d got %0d, corners exp %h got %h",
                       exp_q.face, out_tuser[0], exp_q.corners, out_tdata);
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [fqcp_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      fqcp_pkg::REG_FLIP_EDGE: sh_edge = val[1:0];
      fqcp_pkg::REG_GAIN: sh_gain = val;
      fqcp_pkg::REG_PIVOT_FRONT_X: sh_pfx = val[11:0];
      fqcp_pkg::REG_PIVOT_FRONT_Y: sh_pfy = val[11:0];
      fqcp_pkg::REG_PIVOT_BACK_X: sh_pbx = val[11:0];
      default: sh_pby = val[11:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || sent_count < total_items || expected_quads.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic card_req_t rand_card(bit extreme);
    card_req_t r;
    int mode;
    r.elapsed = 16'($urandom);
    r.duration = 16'($urandom);
    mode = $urandom_range(0, 9);
    if (mode < 5) r.elapsed = 16'($urandom_range(0, r.duration));
    else if (mode == 5) r.duration = 16'd0;
    else if (mode == 6) r.elapsed = r.duration;
    r.fin = ($urandom_range(0, 7) == 0);
    r.back = 1'($urandom);
    r.pos_x = 16'($urandom);
    r.pos_y = 16'($urandom);
    r.fw = extreme ? 12'hFFF : 12'($urandom);
    r.fh = 12'($urandom);
    r.bw = 12'($urandom);
    r.bh = extreme ? 12'hFFF : 12'($urandom);
    if ($urandom_range(0, 15) == 0) r.fw = 12'd0;
    return r;
  endfunction

  task automatic queue_card(card_req_t r);
    pending_reqs.push_back(r);
    total_items++;
  endtask

  initial begin
    card_req_t r;
    logic [15:0] gains[4];
    gains = '{16'd0, 16'hFFFF, fqcp_pkg::GAIN_RESET, 16'd20000};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed
    r = '{16'd0, 16'd100, 1'b0, 1'b0, 16'h7FFF, 16'h8000, 12'hFFF, 12'hFFF, 12'd0, 12'd0};
    queue_card(r);
    r.elapsed = 16'd50; queue_card(r);
    r.elapsed = 16'd51; r.back = 1'b1; queue_card(r);
    r.elapsed = 16'd100; queue_card(r);
    r.elapsed = 16'hFFFF; r.back = 1'b0; queue_card(r);
    r.duration = 16'd0; queue_card(r);
    r.duration = 16'hFFFF; r.elapsed = 16'd1; queue_card(r);
    r.fin = 1'b1; queue_card(r);
    r.back = 1'b1; r.bw = 12'hFFF; r.bh = 12'd7; r.pos_x = 16'h8000; queue_card(r);
    r = '{16'd30, 16'd40, 1'b0, 1'b1, 16'hFFFF, 16'h7FFF, 12'd5, 12'd9, 12'hFFF, 12'hFFF};
    queue_card(r);
    r.elapsed = 16'd10; queue_card(r);
    r.fw = 12'd0; r.fh = 12'd0; r.elapsed = 16'd20; queue_card(r);
    wait_drained();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(fqcp_pkg::REG_FLIP_EDGE, 16'(ph % 4));
      write_reg(fqcp_pkg::REG_GAIN, gains[ph % 4]);
      write_reg(fqcp_pkg::REG_PIVOT_FRONT_X,
                ph == 1 ? 16'hFFF : 16'($urandom_range(0, 4095)));
      write_reg(fqcp_pkg::REG_PIVOT_FRONT_Y,
                ph == 1 ? 16'hFFF : 16'($urandom_range(0, 4095)));
      write_reg(fqcp_pkg::REG_PIVOT_BACK_X,
                ph == 2 ? 16'd0 : 16'($urandom_range(0, 4095)));
      write_reg(fqcp_pkg::REG_PIVOT_BACK_Y,
                ph == 3 ? 16'hFFF : 16'($urandom_range(0, 4095)));
      if (ph == 7) calm = 1;
      for (int i = 0; i < (ph == 7 ? CALM_ITEMS : 240); i++)
        queue_card(rand_card($urandom_range(0, 19) == 0));
      wait_drained();
    end
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
